/* hw/rtl/lr_pkg.sv */
// shared types and field widths for the line rasterizer
`default_nettype none

package lr_pkg;

    localparam int COORD_W = 6;
    localparam int GLYPH_W = 8;
    localparam int ERR_W   = 10;

    localparam int S_TDATA_W = 4 * COORD_W + GLYPH_W;
    localparam int M_TDATA_W = 24;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } lr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } lr_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/line_rasterizer_unit.sv */
// Line rasterizer: turns one line command into the stream of its grid points.
// Input beat on s_*: start point, end point and glyph; coordinates above
// GRID_SIZE-1 are clamped to GRID_SIZE-1. Output beats on m_*: one per
// point, from start to end, each carrying the glyph; m_tlast marks the end
// point. A line with major span N gives N+1 beats.
// Timing: s_tready is high only while no command is in progress. After the
// accept cycle the setup state computes the spans, then the first point is
// presented. The single error accumulator advances one point per beat.
// When the receiver stalls, the current point is held in the point
// registers unchanged and the walk waits. The next command is accepted in the
// cycle after the last point is taken.
// Reset (aresetn low, synchronous) returns the sequencer to idle; any walk in
// progress is dropped. No other state survives between commands.
`default_nettype none

module line_rasterizer_unit
    import lr_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18], glyph[31:24]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // point_x[5:0], point_y[11:6], point_glyph[19:12], zero[23:20]
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    lr_cmd_t            cmd;
    lr_sts_t            sts;
    logic [COORD_W-1:0] point_x, point_y;
    logic [GLYPH_W-1:0] point_glyph;

    lr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lr_dp #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .aclk        (aclk),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_glyph (point_glyph)
    );

    assign m_tdata = {{(M_TDATA_W - 2*COORD_W - GLYPH_W){1'b0}}, point_glyph, point_y, point_x};
    assign m_tlast = sts.last;

    localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(GRID_SIZE - 1);

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a line is being walked");

    a_setup_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!m_tvalid && !s_tready))
        else $error("no setup cycle after command accept");

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("walk did not end after the last point");

    a_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (point_x <= MAX_COORD && point_y <= MAX_COORD))
        else $error("point outside the grid");

endmodule

`default_nettype wire

/* hw/rtl/lr_ctrl.sv */
// sequencer for the line walk: accept, setup, one point per beat
`default_nettype none

module lr_ctrl
    import lr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire lr_sts_t sts,
    output lr_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (m_tready && sts.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_WALK);
    assign cmd.load  = s_tready && s_tvalid;
    assign cmd.setup = (state_reg == ST_SETUP);
    assign cmd.step  = m_tvalid && m_tready && !sts.last;

endmodule

`default_nettype wire

/* hw/rtl/lr_dp.sv */
// datapath: clamped endpoints, spans, error accumulator and point registers
`default_nettype none

module lr_dp
    import lr_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  wire logic               aclk,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire lr_cmd_t            cmd,
    output lr_sts_t                 sts,
    output logic [COORD_W-1:0]      point_x,
    output logic [COORD_W-1:0]      point_y,
    output logic [GLYPH_W-1:0]      point_glyph
);

    localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(GRID_SIZE - 1);

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
        clamp = (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    logic [COORD_W-1:0] in_xs, in_ys, in_xe, in_ye;

    logic [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [COORD_W-1:0] xe_reg, xe_next, ye_reg, ye_next;
    logic [GLYPH_W-1:0] glyph_reg, glyph_next;
    logic [COORD_W-1:0] major_reg, major_next, minor_reg, minor_next;
    logic [COORD_W-1:0] cnt_reg, cnt_next;
    logic               xmaj_reg, xmaj_next, xdec_reg, xdec_next, ydec_reg, ydec_next;
    logic signed [ERR_W-1:0] err_reg, err_next;

    logic [COORD_W-1:0] ax, ay;
    logic               minor_step;
    logic signed [ERR_W-1:0] err_add;
    logic [COORD_W-1:0] x_adv, y_adv;

    assign in_xs = clamp(s_tdata[COORD_W-1:0]);
    assign in_ys = clamp(s_tdata[2*COORD_W-1:COORD_W]);
    assign in_xe = clamp(s_tdata[3*COORD_W-1:2*COORD_W]);
    assign in_ye = clamp(s_tdata[4*COORD_W-1:3*COORD_W]);

    assign ax = (xe_reg >= x_reg) ? (xe_reg - x_reg) : (x_reg - xe_reg);
    assign ay = (ye_reg >= y_reg) ? (ye_reg - y_reg) : (y_reg - ye_reg);

    // error is scaled by twice the major span; a tie does not step
    assign err_add    = err_reg + $signed({3'b000, minor_reg, 1'b0});
    assign minor_step = err_add > $signed({4'b0000, major_reg});
    assign x_adv      = xdec_reg ? (x_reg - COORD_W'(1)) : (x_reg + COORD_W'(1));
    assign y_adv      = ydec_reg ? (y_reg - COORD_W'(1)) : (y_reg + COORD_W'(1));

    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        xe_next    = xe_reg;
        ye_next    = ye_reg;
        glyph_next = glyph_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        cnt_next   = cnt_reg;
        xmaj_next  = xmaj_reg;
        xdec_next  = xdec_reg;
        ydec_next  = ydec_reg;
        err_next   = err_reg;
        if (cmd.load) begin
            x_next     = in_xs;
            y_next     = in_ys;
            xe_next    = in_xe;
            ye_next    = in_ye;
            glyph_next = s_tdata[S_TDATA_W-1:4*COORD_W];
        end else if (cmd.setup) begin
            xmaj_next  = (ax >= ay);
            major_next = (ax >= ay) ? ax : ay;
            minor_next = (ax >= ay) ? ay : ax;
            xdec_next  = (xe_reg < x_reg);
            ydec_next  = (ye_reg < y_reg);
            cnt_next   = '0;
            err_next   = '0;
        end else if (cmd.step) begin
            cnt_next = cnt_reg + COORD_W'(1);
            if (minor_step) begin
                err_next = err_add - $signed({3'b000, major_reg, 1'b0});
            end else begin
                err_next = err_add;
            end
            if (xmaj_reg || minor_step) begin
                x_next = x_adv;
            end
            if (!xmaj_reg || minor_step) begin
                y_next = y_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        xe_reg    <= xe_next;
        ye_reg    <= ye_next;
        glyph_reg <= glyph_next;
        major_reg <= major_next;
        minor_reg <= minor_next;
        cnt_reg   <= cnt_next;
        xmaj_reg  <= xmaj_next;
        xdec_reg  <= xdec_next;
        ydec_reg  <= ydec_next;
        err_reg   <= err_next;
    end

    assign sts.last    = (cnt_reg == major_reg);
    assign point_x     = x_reg;
    assign point_y     = y_reg;
    assign point_glyph = glyph_reg;

endmodule

`default_nettype wire

/* bench/lr_checker.sv */
// point stream checker for the line rasterizer: traces each accepted line and compares beats
`default_nettype none

module lr_checker
    import lr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tlast,
    output int                        fail_count,
    output int                        points_due
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [GLYPH_W-1:0] glyph;
        logic               last;
    } grid_point_t;

    grid_point_t line_points_q[$];

    // walks one line command and queues every grid point it covers
    function automatic void trace_line(input logic [S_TDATA_W-1:0] cmd);
        int          xs, ys, xe, ye;
        int          dx, dy, ax, ay, sx, sy;
        int          span_major, span_minor;
        int          x, y, err;
        bit          x_major;
        grid_point_t p;
        xs = cmd[5:0];
        ys = cmd[11:6];
        xe = cmd[17:12];
        ye = cmd[23:18];
        dx = xe - xs;
        dy = ye - ys;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        // equal spans go along x
        x_major    = (ax >= ay);
        span_major = x_major ? ax : ay;
        span_minor = x_major ? ay : ax;
        x   = xs;
        y   = ys;
        err = 0;
        for (int i = 0; i <= span_major; i++) begin
            p.x     = x[COORD_W-1:0];
            p.y     = y[COORD_W-1:0];
            p.glyph = cmd[31:24];
            p.last  = (i == span_major);
            line_points_q.push_back(p);
            err += 2 * span_minor;
            // a tie at exactly one half holds the minor coordinate
            if (x_major) begin
                x += sx;
                if (err > span_major) begin
                    y   += sy;
                    err -= 2 * span_major;
                end
            end else begin
                y += sy;
                if (err > span_major) begin
                    x   += sx;
                    err -= 2 * span_major;
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        grid_point_t want;
        int          errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                trace_line(s_tdata);
            if (m_tvalid && m_tready) begin
                if (line_points_q.size() == 0) begin
                    $error("point beat with nothing expected: tdata %h tlast %b",
                           m_tdata, m_tlast);
                    errs++;
                end else begin
                    want = line_points_q.pop_front();
                    if (m_tdata[5:0] !== want.x) begin
                        $error("point_x: expected %0d, got %0d", want.x, m_tdata[5:0]);
                        errs++;
                    end
                    if (m_tdata[11:6] !== want.y) begin
                        $error("point_y: expected %0d, got %0d", want.y, m_tdata[11:6]);
                        errs++;
                    end
                    if (m_tdata[19:12] !== want.glyph) begin
                        $error("point_glyph: expected %0d, got %0d",
                               want.glyph, m_tdata[19:12]);
                        errs++;
                    end
                    if (m_tdata[23:20] !== 4'd0) begin
                        $error("zero pad: expected 0, got %0d", m_tdata[23:20]);
                        errs++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_point: expected %0d, got %0d", want.last, m_tlast);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        points_due <= line_points_q.size();
    end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// testbench top for the line rasterizer: drives line commands and gives the verdict
`default_nettype none

module tb_top
    import lr_pkg::*;
;

    localparam int RANDOM_LINES = 250;
    localparam int PHASES       = 5;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    int                   fail_count;
    int                   points_due;
    int                   src_idle_pct  = 0;
    int                   sink_stall_pct = 0;

    line_rasterizer_unit #(.GRID_SIZE(64)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    lr_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .fail_count(fail_count),
        .points_due(points_due)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        #8_000_000;
        $display("[line_rasterizer_unit] ERROR");
        $finish;
    end

    // holds tvalid across back-to-back commands; only drops it for a gap
    task automatic send_line(input int xs, input int ys, input int xe, input int ye,
                             input int glyph);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {glyph[7:0], ye[5:0], xe[5:0], ys[5:0], xs[5:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic int near_coord(input int c);
        int v;
        v = c + $urandom_range(14) - 7;
        if (v < 0) v = 0;
        if (v > 63) v = 63;
        return v;
    endfunction

    initial begin
        int idle_tbl[PHASES];
        int stall_tbl[PHASES];
        int xs, ys, phase, waited;
        idle_tbl  = '{0, 83, 0, 21, 0};
        stall_tbl = '{0, 0, 83, 21, 0};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single points, full diagonals, axis lines both ways, tie, steep and shallow
        send_line( 0,  0,  0,  0, 8'h00);
        send_line(63, 63, 63, 63, 8'hFF);
        send_line( 0,  0, 63, 63, 8'hAA);
        send_line(63, 63,  0,  0, 8'h55);
        send_line( 0, 63, 63,  0, 8'h0F);
        send_line(63,  0,  0, 63, 8'hF0);
        send_line( 0, 10, 63, 10, 8'h23);
        send_line(63, 10,  0, 10, 8'h24);
        send_line(20,  0, 20, 63, 8'h7C);
        send_line(20, 63, 20,  0, 8'h7D);
        send_line( 0,  0,  4,  2, 8'h2A);
        send_line( 4,  2,  0,  0, 8'h2B);
        send_line( 2,  0,  0,  4, 8'h2C);
        send_line( 0,  0, 63,  1, 8'h2D);
        send_line( 0,  0,  1, 63, 8'h2E);
        send_line(63,  0, 62, 63, 8'h80);
        send_line(10, 40, 50, 30, 8'h81);
        send_line(30,  5, 33, 60, 8'h01);
        send_line( 5,  5,  6,  5, 8'hFE);
        send_line( 5,  5,  5,  4, 8'h7F);
        send_line(63,  0,  0, 62, 8'h40);

        for (int n = 0; n < RANDOM_LINES; n++) begin
            phase          = n * PHASES / RANDOM_LINES;
            src_idle_pct   = idle_tbl[phase];
            sink_stall_pct = stall_tbl[phase];
            if ($urandom_range(2) == 0) begin
                send_line($urandom_range(63), $urandom_range(63), $urandom_range(63),
                          $urandom_range(63), $urandom_range(255));
            end else begin
                // mostly short lines keep the run brisk
                xs = $urandom_range(63);
                ys = $urandom_range(63);
                send_line(xs, ys, near_coord(xs), near_coord(ys), $urandom_range(255));
            end
        end
        s_tvalid       <= 1'b0;
        sink_stall_pct  = 0;

        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (points_due != 0 && waited < 20000);
        repeat (70) @(posedge aclk);

        if (fail_count == 0 && points_due == 0) begin
            $display("[line_rasterizer_unit] OK");
        end else begin
            $display("[line_rasterizer_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
